// File: hw/rtl/json_string_unescape_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define JSU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("json_string_unescape: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define JSU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("json_string_unescape: next-cycle check failed");

`endif

// File: hw/rtl/jsu_pkg.sv
package jsu_pkg;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_BYTE  = 2'd1;
   localparam logic [1:0] MODE_END   = 2'd2;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   localparam logic [5:0] SUR_HIGH_TOP = 6'b110110;
   localparam logic [5:0] SUR_LOW_TOP  = 6'b110111;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_TEXT   = 4'd1,
      PH_ESC    = 4'd2,
      PH_HEX1   = 4'd3,
      PH_SUR_BS = 4'd4,
      PH_SUR_U  = 4'd5,
      PH_HEX2   = 4'd6,
      PH_UTF8   = 4'd7,
      PH_HALT   = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ERR_UNTERM    = 4'd0,
      ERR_BAD_ESC   = 4'd1,
      ERR_BAD_HEX   = 4'd2,
      ERR_NO_BSLASH = 4'd3,
      ERR_NO_U      = 4'd4,
      ERR_LOW_RANGE = 4'd5,
      ERR_DANGLING  = 4'd6,
      ERR_BAD_LEAD  = 4'd7,
      ERR_BAD_UTF8  = 4'd8,
      ERR_CONTROL   = 4'd9
   } err_type;

   typedef struct packed {
      logic [2:0]      cnt;
      logic [3:0][7:0] bytes;
   } enc_type;

   // Returns {valid, digit value}.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Sequence length announced by a lead byte at or above 0x80; zero if illegal.
   function automatic logic [2:0] lead_length(input logic [7:0] u);
      logic [2:0] r;
      if (u < 8'hC2) begin
         r = 3'd0;
      end else if (u <= 8'hDF) begin
         r = 3'd2;
      end else if (u <= 8'hEF) begin
         r = 3'd3;
      end else if (u <= 8'hF4) begin
         r = 3'd4;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic logic is_cont(input logic [7:0] x);
      return x[7:6] == 2'b10;
   endfunction

   // The second byte range depends on the lead, which rules out overlong
   // forms, surrogates and code points above the Unicode range.
   function automatic logic legal_seq(input logic [3:0][7:0] b, input logic [2:0] len);
      logic       ok;
      logic [7:0] a;
      ok = 1'b1;
      a  = b[1];
      if (len >= 3'd3 && !is_cont(b[2])) ok = 1'b0;
      if (len >= 3'd4 && !is_cont(b[3])) ok = 1'b0;
      if (len >= 3'd2) begin
         case (b[0])
            8'hE0:   if (a < 8'hA0 || a > 8'hBF) ok = 1'b0;
            8'hED:   if (a < 8'h80 || a > 8'h9F) ok = 1'b0;
            8'hF0:   if (a < 8'h90 || a > 8'hBF) ok = 1'b0;
            8'hF4:   if (a < 8'h80 || a > 8'h8F) ok = 1'b0;
            default: if (!is_cont(a)) ok = 1'b0;
         endcase
      end
      if (b[0] >= 8'h80 && b[0] < 8'hC2) ok = 1'b0;
      if (b[0] > 8'hF4) ok = 1'b0;
      return ok;
   endfunction

   function automatic enc_type utf8_encode(input logic [20:0] cp);
      enc_type e;
      e.bytes = '0;
      if (cp < 21'h80) begin
         e.cnt      = 3'd1;
         e.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         e.cnt      = 3'd2;
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         e.cnt      = 3'd3;
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         e.cnt      = 3'd4;
         e.bytes[0] = {5'b11110, cp[20:18]};
         e.bytes[1] = {2'b10, cp[17:12]};
         e.bytes[2] = {2'b10, cp[11:6]};
         e.bytes[3] = {2'b10, cp[5:0]};
      end
      return e;
   endfunction

endpackage

// File: hw/rtl/json_string_unescape.sv
// Channel   Direction  Handshake          Word
// req       in         req_valid/stall    req_mode, req_in_byte
// rsp       out        rsp_valid/stall    rsp_kind, rsp_out_byte, rsp_error_code, rsp_last
//
// A word is held in the input register, decoded combinationally into a group
// of up to four results in the result group register, and the group drains one
// result per cycle while rsp_stall is low. One input word per cycle while each
// gives at most one result and rsp_stall is low; else the next word waits for the last.
// Reset is synchronous and leaves no string open. req_stall rises only when
// the input register is full and the result group cannot be replaced.
`include "json_string_unescape_macros.svh"

module json_string_unescape import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_error_code,
   output logic       rsp_last
);

   // Input register.
   logic       in_vld_ff, in_vld_in;
   logic [1:0] in_mode_ff;
   logic [7:0] in_byte_ff;

   // Decoder state.
   phase_type       phase_ff, phase_in;
   logic [15:0]     hex_accum_ff, hex_accum_in;
   logic [1:0]      hex_count_ff, hex_count_in;
   logic [9:0]      high_sur_ff, high_sur_in;
   logic [3:0][7:0] hold_ff, hold_in;
   logic [2:0]      utf8_expect_ff, utf8_expect_in;
   logic [2:0]      utf8_seen_ff, utf8_seen_in;

   // Result group register.
   logic [2:0]      grp_cnt_ff, grp_cnt_in;
   kind_type        grp_kind_ff, grp_kind_in;
   err_type         grp_code_ff, grp_code_in;
   logic [3:0][7:0] grp_byte_ff, grp_byte_in;

   // Decoded group for the word in the input register.
   logic [2:0]      dec_cnt;
   kind_type        dec_kind;
   err_type         dec_code;
   logic [3:0][7:0] dec_bytes;

   logic            req_take, rsp_take, grp_free, advance, active;
   logic [7:0]      c;
   logic [4:0]      hex_res;
   logic [15:0]     accum_new;
   logic            hex_done, is_high, is_low;
   logic [20:0]     cp;
   enc_type         enc;
   logic [2:0]      seen_new, lead;
   logic [3:0][7:0] hold_new;
   logic            seq_done, seq_ok;

   assign rsp_valid = grp_cnt_ff != 3'd0;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign grp_free  = (grp_cnt_ff == 3'd0) || (grp_cnt_ff == 3'd1 && rsp_take);
   assign advance   = in_vld_ff && grp_free;
   assign req_stall = in_vld_ff && !grp_free;
   assign req_take  = req_valid && !req_stall;

   assign rsp_kind       = grp_kind_ff;
   assign rsp_out_byte   = grp_byte_ff[0];
   assign rsp_error_code = grp_code_ff;
   assign rsp_last       = grp_cnt_ff == 3'd1;

   // Shared decode terms.
   assign c         = in_byte_ff;
   assign active    = (in_mode_ff == MODE_BYTE || in_mode_ff == MODE_END) &&
                      phase_ff != PH_IDLE && phase_ff != PH_HALT;
   assign hex_res   = hex_value(c);
   assign accum_new = {hex_accum_ff[11:0], hex_res[3:0]};
   assign hex_done  = hex_count_ff == 2'd3;
   assign is_high   = accum_new[15:10] == SUR_HIGH_TOP;
   assign is_low    = accum_new[15:10] == SUR_LOW_TOP;
   assign cp        = (phase_ff == PH_HEX2) ?
                      21'h10000 + {1'b0, high_sur_ff, accum_new[9:0]} :
                      {5'd0, accum_new};
   assign enc       = utf8_encode(cp);
   assign seen_new  = utf8_seen_ff + 3'd1;
   assign seq_done  = seen_new >= utf8_expect_ff;
   assign seq_ok    = legal_seq(hold_new, utf8_expect_ff);
   assign lead      = lead_length(c);

   always_comb begin
      hold_new = hold_ff;
      hold_new[utf8_seen_ff[1:0]] = c;
   end

   // Next state of the decoder.
   always_comb begin
      phase_in       = phase_ff;
      hex_accum_in   = hex_accum_ff;
      hex_count_in   = hex_count_ff;
      high_sur_in    = high_sur_ff;
      hold_in        = hold_ff;
      utf8_expect_in = utf8_expect_ff;
      utf8_seen_in   = utf8_seen_ff;
      if (advance) begin
         if (in_mode_ff == MODE_START) begin
            phase_in       = PH_TEXT;
            hex_accum_in   = '0;
            hex_count_in   = '0;
            high_sur_in    = '0;
            utf8_expect_in = '0;
            utf8_seen_in   = '0;
         end else if (active && in_mode_ff == MODE_END) begin
            phase_in = PH_HALT;
         end else if (active) begin
            unique case (phase_ff)
               PH_TEXT: begin
                  if (c == CHAR_QUOTE) begin
                     phase_in = PH_IDLE;
                  end else if (c == CHAR_BSLASH) begin
                     phase_in = PH_ESC;
                  end else if (c[7]) begin
                     if (lead == 3'd0) begin
                        phase_in = PH_HALT;
                     end else begin
                        hold_in[0]     = c;
                        utf8_expect_in = lead;
                        utf8_seen_in   = 3'd1;
                        phase_in       = PH_UTF8;
                     end
                  end else if (c < CHAR_SPACE) begin
                     phase_in = PH_HALT;
                  end
               end
               PH_ESC: begin
                  case (c) inside
                     CHAR_BSLASH, CHAR_B, CHAR_F, CHAR_N, CHAR_R, CHAR_T,
                     CHAR_SLASH, CHAR_QUOTE: phase_in = PH_TEXT;
                     CHAR_U: begin
                        hex_accum_in = '0;
                        hex_count_in = '0;
                        phase_in     = PH_HEX1;
                     end
                     default: phase_in = PH_HALT;
                  endcase
               end
               PH_HEX1, PH_HEX2: begin
                  if (!hex_res[4]) begin
                     phase_in = PH_HALT;
                  end else begin
                     hex_accum_in = accum_new;
                     hex_count_in = hex_count_ff + 2'd1;
                     if (hex_done) begin
                        if (phase_ff == PH_HEX1) begin
                           if (is_high) begin
                              high_sur_in = accum_new[9:0];
                              phase_in    = PH_SUR_BS;
                           end else if (is_low) begin
                              phase_in = PH_HALT;
                           end else begin
                              phase_in = PH_TEXT;
                           end
                        end else begin
                           phase_in = is_low ? PH_TEXT : PH_HALT;
                        end
                     end
                  end
               end
               PH_SUR_BS: phase_in = (c == CHAR_BSLASH) ? PH_SUR_U : PH_HALT;
               PH_SUR_U: begin
                  if (c == CHAR_U) begin
                     hex_accum_in = '0;
                     hex_count_in = '0;
                     phase_in     = PH_HEX2;
                  end else begin
                     phase_in = PH_HALT;
                  end
               end
               PH_UTF8: begin
                  hold_in      = hold_new;
                  utf8_seen_in = seen_new;
                  if (seq_done) begin
                     phase_in = seq_ok ? PH_TEXT : PH_HALT;
                  end
               end
               default: phase_in = PH_HALT;
            endcase
         end
      end
   end

   // Results of the word in the input register.
   always_comb begin
      dec_cnt   = 3'd0;
      dec_kind  = KIND_DATA;
      dec_code  = ERR_UNTERM;
      dec_bytes = '0;
      if (active && in_mode_ff == MODE_END) begin
         dec_cnt  = 3'd1;
         dec_kind = KIND_ERROR;
         dec_code = ERR_UNTERM;
      end else if (active) begin
         unique case (phase_ff)
            PH_TEXT: begin
               if (c == CHAR_QUOTE) begin
                  dec_cnt  = 3'd1;
                  dec_kind = KIND_END;
               end else if (c == CHAR_BSLASH) begin
                  dec_cnt = 3'd0;
               end else if (c[7]) begin
                  if (lead == 3'd0) begin
                     dec_cnt  = 3'd1;
                     dec_kind = KIND_ERROR;
                     dec_code = ERR_BAD_LEAD;
                  end
               end else if (c < CHAR_SPACE) begin
                  dec_cnt  = 3'd1;
                  dec_kind = KIND_ERROR;
                  dec_code = ERR_CONTROL;
               end else begin
                  dec_cnt      = 3'd1;
                  dec_bytes[0] = c;
               end
            end
            PH_ESC: begin
               dec_cnt = 3'd1;
               case (c)
                  CHAR_BSLASH: dec_bytes[0] = 8'h5C;
                  CHAR_B:      dec_bytes[0] = 8'h08;
                  CHAR_F:      dec_bytes[0] = 8'h0C;
                  CHAR_N:      dec_bytes[0] = 8'h0A;
                  CHAR_R:      dec_bytes[0] = 8'h0D;
                  CHAR_T:      dec_bytes[0] = 8'h09;
                  CHAR_SLASH:  dec_bytes[0] = 8'h2F;
                  CHAR_QUOTE:  dec_bytes[0] = 8'h22;
                  CHAR_U:      dec_cnt = 3'd0;
                  default: begin
                     dec_kind = KIND_ERROR;
                     dec_code = ERR_BAD_ESC;
                  end
               endcase
            end
            PH_HEX1, PH_HEX2: begin
               if (!hex_res[4]) begin
                  dec_cnt  = 3'd1;
                  dec_kind = KIND_ERROR;
                  dec_code = ERR_BAD_HEX;
               end else if (hex_done) begin
                  if (phase_ff == PH_HEX1 && is_high) begin
                     dec_cnt = 3'd0;
                  end else if (phase_ff == PH_HEX1 && is_low) begin
                     dec_cnt  = 3'd1;
                     dec_kind = KIND_ERROR;
                     dec_code = ERR_DANGLING;
                  end else if (phase_ff == PH_HEX2 && !is_low) begin
                     dec_cnt  = 3'd1;
                     dec_kind = KIND_ERROR;
                     dec_code = ERR_LOW_RANGE;
                  end else begin
                     dec_cnt   = enc.cnt;
                     dec_bytes = enc.bytes;
                  end
               end
            end
            PH_SUR_BS: begin
               if (c != CHAR_BSLASH) begin
                  dec_cnt  = 3'd1;
                  dec_kind = KIND_ERROR;
                  dec_code = ERR_NO_BSLASH;
               end
            end
            PH_SUR_U: begin
               if (c != CHAR_U) begin
                  dec_cnt  = 3'd1;
                  dec_kind = KIND_ERROR;
                  dec_code = ERR_NO_U;
               end
            end
            PH_UTF8: begin
               if (seq_done) begin
                  if (seq_ok) begin
                     dec_cnt   = utf8_expect_ff;
                     dec_bytes = hold_new;
                  end else begin
                     dec_cnt  = 3'd1;
                     dec_kind = KIND_ERROR;
                     dec_code = ERR_BAD_UTF8;
                  end
               end
            end
            default: dec_cnt = 3'd0;
         endcase
      end
   end

   // Result group: load a fresh group on advance, else shift out taken words.
   always_comb begin
      grp_cnt_in  = grp_cnt_ff;
      grp_kind_in = grp_kind_ff;
      grp_code_in = grp_code_ff;
      grp_byte_in = grp_byte_ff;
      if (advance) begin
         grp_cnt_in  = dec_cnt;
         grp_kind_in = dec_kind;
         grp_code_in = dec_code;
         grp_byte_in = dec_bytes;
      end else if (rsp_take) begin
         grp_cnt_in  = grp_cnt_ff - 3'd1;
         grp_byte_in = grp_byte_ff >> 8;
      end
   end

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff      <= 1'b0;
         phase_ff       <= PH_IDLE;
         hex_accum_ff   <= '0;
         hex_count_ff   <= '0;
         high_sur_ff    <= '0;
         utf8_expect_ff <= '0;
         utf8_seen_ff   <= '0;
         grp_cnt_ff     <= '0;
      end else begin
         in_vld_ff      <= in_vld_in;
         phase_ff       <= phase_in;
         hex_accum_ff   <= hex_accum_in;
         hex_count_ff   <= hex_count_in;
         high_sur_ff    <= high_sur_in;
         utf8_expect_ff <= utf8_expect_in;
         utf8_seen_ff   <= utf8_seen_in;
         grp_cnt_ff     <= grp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= req_mode;
         in_byte_ff <= req_in_byte;
      end
      hold_ff     <= hold_in;
      grp_kind_ff <= grp_kind_in;
      grp_code_ff <= grp_code_in;
      grp_byte_ff <= grp_byte_in;
   end

   // An error is shown only after the decoder has halted.
   `JSU_ASSERT_NOW(a_error_halts, rsp_valid && rsp_kind == KIND_ERROR, phase_ff == PH_HALT)
   // A closing quote leaves no string open while its word is shown.
   `JSU_ASSERT_NOW(a_end_idle, rsp_valid && rsp_kind == KIND_END, phase_ff == PH_IDLE)
   // Error and end words are always the only word of their group.
   `JSU_ASSERT_NOW(a_single_ctrl, rsp_valid && rsp_kind != KIND_DATA, rsp_last)
   // A group never holds more than four words.
   `JSU_ASSERT_NOW(a_grp_bound, 1'b1, grp_cnt_ff <= 3'd4)
   // Taking a word that is not the last leaves the rest of the group pending.
   `JSU_ASSERT_NEXT(a_grp_cont, rsp_take && !rsp_last, rsp_valid)

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import jsu_pkg::*;

   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam logic [3:0] NO_CODE   = 4'd0;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [3:0] code;
      logic       last;
   } result_word;

   typedef struct {
      logic [1:0] mode;
      logic [7:0] data;
      bit         typed;
      int         n_res;
      kind_type   kind;
      logic [7:0] val;
      logic [3:0] code;
   } stim_row;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_mode = MODE_START;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [3:0] rsp_error_code;
   logic       rsp_last;

   int         req_gap_pct = 0;
   int         rsp_hold_pct = 0;
   int         mismatches = 0;
   int         live_words = 0;

   result_word decoded_q [$];
   result_word word_results [$];

   // Decoder state as the predictor sees it.
   phase_type  ph = PH_IDLE;
   logic [15:0] hex_acc = '0;
   logic [1:0] hex_n = '0;
   logic [9:0] hi_half = '0;
   logic [7:0] raw_hold [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
   logic [2:0] raw_len = '0;
   logic [2:0] raw_got = '0;

   logic [7:0] short_escapes [8] = '{CHAR_BSLASH, CHAR_SLASH, CHAR_QUOTE, CHAR_B,
                                     CHAR_F, CHAR_N, CHAR_R, CHAR_T};

   // Rows with a typed result bypass the predictor for the expectation only.
   stim_row directed_rows [25] = '{
      '{MODE_BYTE,  8'h41,       1'b1, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_START, 8'h00,       1'b1, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_NONE,  8'hFF,       1'b1, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  8'h7F,       1'b1, 1, KIND_DATA,  8'h7F, NO_CODE},
      '{MODE_BYTE,  8'hE2,       1'b1, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  CHAR_QUOTE,  1'b1, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  8'h80,       1'b1, 1, KIND_ERROR, 8'h00, ERR_BAD_UTF8},
      '{MODE_END,   8'h00,       1'b1, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_START, 8'hFF,       1'b0, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  CHAR_BSLASH, 1'b0, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  CHAR_U,      1'b0, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  8'h64,       1'b0, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  8'h38,       1'b0, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  8'h30,       1'b0, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  8'h30,       1'b0, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  CHAR_BSLASH, 1'b0, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  CHAR_U,      1'b0, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  8'h30,       1'b0, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  8'h30,       1'b0, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  8'h34,       1'b0, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  8'h46,       1'b1, 1, KIND_ERROR, 8'h00, ERR_LOW_RANGE},
      '{MODE_START, 8'h00,       1'b1, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_BYTE,  8'h1F,       1'b1, 1, KIND_ERROR, 8'h00, ERR_CONTROL},
      '{MODE_START, 8'h00,       1'b1, 0, KIND_DATA,  8'h00, NO_CODE},
      '{MODE_END,   8'hA5,       1'b1, 1, KIND_ERROR, 8'h00, ERR_UNTERM}
   };

   json_string_unescape u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic emit_byte(input logic [7:0] b);
      result_word r;
      r = '{KIND_DATA, b, NO_CODE, 1'b0};
      word_results.push_back(r);
   endtask

   task automatic raise_error(input err_type e);
      result_word r;
      ph = PH_HALT;
      r = '{KIND_ERROR, 8'h00, e, 1'b0};
      word_results.push_back(r);
   endtask

   // UTF-8 form of a code point: a lead byte carrying the top bits, then
   // six bits per continuation byte.
   task automatic emit_code_point(input logic [20:0] cp);
      int n;
      logic [7:0] lead_mask;
      logic [7:0] b;
      n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
      if (n == 1) begin
         emit_byte(cp[7:0]);
      end else begin
         lead_mask = 8'hFF << (8 - n);
         b = cp >> (6 * (n - 1));
         emit_byte(lead_mask | b);
         for (int i = n - 2; i >= 0; i--) begin
            b = (cp >> (6 * i)) & 21'h3F;
            emit_byte(8'h80 | b);
         end
      end
      ph = PH_TEXT;
   endtask

   task automatic decode_word(input logic [1:0] m, input logic [7:0] c, output bit taken);
      result_word r;
      int d;
      logic [7:0] lo;
      logic [7:0] hi;
      bit ok;
      word_results.delete();
      taken = 1'b1;
      if (m == MODE_START) begin
         ph = PH_TEXT;
         hex_acc = '0;
         hex_n = '0;
         hi_half = '0;
         raw_len = '0;
         raw_got = '0;
         return;
      end
      if (m == MODE_NONE || ph == PH_IDLE || ph == PH_HALT) begin
         taken = 1'b0;
         return;
      end
      if (m == MODE_END) begin
         raise_error(ERR_UNTERM);
      end else begin
         case (ph)
            PH_TEXT: begin
               if (c == CHAR_QUOTE) begin
                  ph = PH_IDLE;
                  r = '{KIND_END, 8'h00, NO_CODE, 1'b0};
                  word_results.push_back(r);
               end else if (c == CHAR_BSLASH) begin
                  ph = PH_ESC;
               end else if (c >= 8'h80) begin
                  if (c < 8'hC2 || c > 8'hF4) begin
                     raise_error(ERR_BAD_LEAD);
                  end else begin
                     raw_hold[0] = c;
                     raw_len = (c <= 8'hDF) ? 3'd2 : (c <= 8'hEF) ? 3'd3 : 3'd4;
                     raw_got = 3'd1;
                     ph = PH_UTF8;
                  end
               end else if (c < CHAR_SPACE) begin
                  raise_error(ERR_CONTROL);
               end else begin
                  emit_byte(c);
               end
            end
            PH_ESC: begin
               ph = PH_TEXT;
               case (c)
                  CHAR_B: emit_byte(8'h08);
                  CHAR_F: emit_byte(8'h0C);
                  CHAR_N: emit_byte(8'h0A);
                  CHAR_R: emit_byte(8'h0D);
                  CHAR_T: emit_byte(8'h09);
                  CHAR_BSLASH, CHAR_SLASH, CHAR_QUOTE: emit_byte(c);
                  CHAR_U: begin
                     hex_acc = '0;
                     hex_n = '0;
                     ph = PH_HEX1;
                  end
                  default: raise_error(ERR_BAD_ESC);
               endcase
            end
            PH_HEX1, PH_HEX2: begin
               if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
               else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h61 + 10;
               else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h41 + 10;
               else d = -1;
               if (d < 0) begin
                  raise_error(ERR_BAD_HEX);
               end else begin
                  hex_acc = {hex_acc[11:0], d[3:0]};
                  if (hex_n != 2'd3) begin
                     hex_n++;
                  end else begin
                     hex_n = '0;
                     if (ph == PH_HEX1) begin
                        if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                           hi_half = hex_acc[9:0];
                           ph = PH_SUR_BS;
                        end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                           raise_error(ERR_DANGLING);
                        end else begin
                           emit_code_point({5'd0, hex_acc});
                        end
                     end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                        raise_error(ERR_LOW_RANGE);
                     end else begin
                        emit_code_point(21'h10000 + {hi_half, hex_acc[9:0]});
                     end
                  end
               end
            end
            PH_SUR_BS: begin
               if (c != CHAR_BSLASH) raise_error(ERR_NO_BSLASH);
               else ph = PH_SUR_U;
            end
            PH_SUR_U: begin
               if (c != CHAR_U) begin
                  raise_error(ERR_NO_U);
               end else begin
                  hex_acc = '0;
                  hex_n = '0;
                  ph = PH_HEX2;
               end
            end
            PH_UTF8: begin
               raw_hold[raw_got[1:0]] = c;
               raw_got++;
               if (raw_got >= raw_len) begin
                  // The allowed range of the second byte depends on the lead.
                  lo = 8'h80;
                  hi = 8'hBF;
                  case (raw_hold[0])
                     8'hE0: lo = 8'hA0;
                     8'hED: hi = 8'h9F;
                     8'hF0: lo = 8'h90;
                     8'hF4: hi = 8'h8F;
                     default: ;
                  endcase
                  ok = (raw_hold[1] >= lo && raw_hold[1] <= hi);
                  for (int i = 2; i < raw_len; i++) begin
                     if (raw_hold[i][7:6] != 2'b10) ok = 1'b0;
                  end
                  if (!ok) begin
                     raise_error(ERR_BAD_UTF8);
                  end else begin
                     for (int i = 0; i < raw_len; i++) emit_byte(raw_hold[i]);
                     ph = PH_TEXT;
                  end
               end
            end
            default: ph = PH_HALT;
         endcase
      end
      if (word_results.size() > 0) begin
         r = word_results.pop_back();
         r.last = 1'b1;
         word_results.push_back(r);
      end
   endtask

   task automatic send_word(input logic [1:0] m, input logic [7:0] c, input bit typed,
                            input int typed_n, input result_word typed_res);
      bit taken;
      if ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_gap_pct);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_in_byte <= c;
      do @(posedge clock); while (req_stall);
      decode_word(m, c, taken);
      if (taken) live_words++;
      if (typed) begin
         if (typed_n > 0) decoded_q.push_back(typed_res);
      end else begin
         foreach (word_results[i]) decoded_q.push_back(word_results[i]);
      end
   endtask

   task automatic put_word(input logic [1:0] m, input logic [7:0] c);
      send_word(m, c, 1'b0, 0, '0);
   endtask

   // Now and then a content byte is swapped for noise to break a sequence.
   task automatic put_char(input logic [7:0] c);
      if ($urandom_range(63) == 0) c = $urandom;
      send_word(MODE_BYTE, c, 1'b0, 0, '0);
   endtask

   task automatic put_hex(input logic [15:0] v);
      logic [3:0] d;
      for (int i = 3; i >= 0; i--) begin
         d = v[4*i +: 4];
         if (d < 4'd10) put_char(8'h30 + d);
         else put_char(($urandom_range(1) ? 8'h61 : 8'h41) + d - 8'd10);
      end
   endtask

   task automatic send_string(input int n_parts);
      logic [7:0] c;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [15:0] v;
      int n;
      int brk;
      put_word(MODE_START, $urandom);
      repeat (n_parts) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               c = $urandom_range(8'h7F, 8'h20);
               if (c == CHAR_QUOTE || c == CHAR_BSLASH) c = 8'h61;
               put_char(c);
            end
            4: begin
               put_char(CHAR_BSLASH);
               put_char(short_escapes[$urandom_range(7)]);
            end
            5: begin
               case ($urandom_range(3))
                  0: v = $urandom_range(16'h007F);
                  1: v = $urandom_range(16'h07FF, 16'h0080);
                  2: v = $urandom_range(1) ? $urandom_range(16'hD7FF, 16'h0800)
                                           : $urandom_range(16'hFFFF, 16'hE000);
                  default: v = $urandom;
               endcase
               put_char(CHAR_BSLASH);
               put_char(CHAR_U);
               put_hex(v);
            end
            6: begin
               brk = $urandom_range(5);
               put_char(CHAR_BSLASH);
               put_char(CHAR_U);
               put_hex($urandom_range(16'hDBFF, 16'hD800));
               put_char(brk == 0 ? $urandom : CHAR_BSLASH);
               put_char(brk == 1 ? $urandom : CHAR_U);
               put_hex(brk == 2 ? $urandom : $urandom_range(16'hDFFF, 16'hDC00));
            end
            7, 8: begin
               n = $urandom_range(4, 2);
               if (n == 2) c = $urandom_range(8'hDF, 8'hC2);
               else if (n == 3) c = $urandom_range(8'hEF, 8'hE0);
               else c = $urandom_range(8'hF4, 8'hF0);
               lo = 8'h80;
               hi = 8'hBF;
               if (c == 8'hE0) lo = 8'hA0;
               if (c == 8'hED) hi = 8'h9F;
               if (c == 8'hF0) lo = 8'h90;
               if (c == 8'hF4) hi = 8'h8F;
               put_char(c);
               put_char($urandom_range(hi, lo));
               repeat (n - 2) put_char($urandom_range(8'hBF, 8'h80));
            end
            default: put_word($urandom_range(3), $urandom);
         endcase
      end
      if ($urandom_range(7) == 0) put_word(MODE_END, $urandom);
      else put_char(CHAR_QUOTE);
   endtask

   always @(posedge clock) begin : rsp_side
      result_word want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: unexpected word kind=%0d byte=%h code=%0d last=%0b", $time,
                        rsp_kind, rsp_out_byte, rsp_error_code, rsp_last);
               mismatches++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_kind !== want.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_kind);
                  mismatches++;
               end
               if (rsp_out_byte !== want.data) begin
                  $display("%0t: out_byte expected %h actual %h", $time, want.data,
                           rsp_out_byte);
                  mismatches++;
               end
               if (rsp_error_code !== want.code) begin
                  $display("%0t: error_code expected %0d actual %0d", $time, want.code,
                           rsp_error_code);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
      end
   end

   initial begin : stimulus
      result_word typed_res;
      int idle_plan [4][2];
      int goal;
      idle_plan = '{'{0, 0}, '{45, 0}, '{0, 45}, '{35, 35}};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_res = '{directed_rows[i].kind, directed_rows[i].val, directed_rows[i].code, 1'b1};
         send_word(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].typed,
                   directed_rows[i].n_res, typed_res);
      end

      for (int p = 0; p < 4; p++) begin
         req_gap_pct = idle_plan[p][0];
         rsp_hold_pct = idle_plan[p][1];
         goal = live_words + 30;
         while (live_words < goal) send_string($urandom_range(6, 1));
      end

      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("%0t: timeout, %0d words still expected", $time, decoded_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/jsu_pkg.sv
hw/rtl/json_string_unescape.sv
sim/tb_top.sv
